@@ src/motion_magnitude_fall_detect_top_defines.svh @@
// Assertion macros shared by the checker.
`ifndef MOTION_MAGNITUDE_FALL_DETECT_TOP_DEFINES_SVH
`define MOTION_MAGNITUDE_FALL_DETECT_TOP_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define MMFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// The expression must never be true outside reset.
`define MMFD_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

@@ src/mmfd_pkg.sv @@
package mmfd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ANGLE_W  = 16;
    localparam int TILT_W   = 15;
    localparam int MAG_W    = 16;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int LANE_LAT = ROOT_W + 2;
    localparam int OUT_LAT  = LANE_LAT + 1;

    localparam logic [TILT_W-1:0] TILT_RESET = TILT_W'(6000);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] rate_x;
        logic signed [SAMPLE_W-1:0] rate_y;
        logic signed [SAMPLE_W-1:0] rate_z;
        logic signed [ANGLE_W-1:0]  pitch_angle;
        logic signed [ANGLE_W-1:0]  roll_angle;
    } t_in_item;

    typedef struct packed {
        logic [MAG_W-1:0] accel_magnitude;
        logic [MAG_W-1:0] rate_magnitude;
        logic             fall_detected;
    } t_result;

endpackage

@@ src/mmfd_lane.sv @@
module mmfd_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [mmfd_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [mmfd_pkg::SAMPLE_W-1:0] i_y,
    input  logic signed [mmfd_pkg::SAMPLE_W-1:0] i_z,
    output logic                                o_vld,
    output logic [mmfd_pkg::ROOT_W-1:0]         o_root
);
    import mmfd_pkg::*;

    function automatic logic [SAMPLE_W-1:0] abs_val(input logic [SAMPLE_W-1:0] v);
        return v[SAMPLE_W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [SQ_W-1:0]  r_sq_x;
    logic [SQ_W-1:0]  r_sq_y;
    logic [SQ_W-1:0]  r_sq_z;
    logic             r_vld_sq;
    logic [SUM_W-1:0] r_sum;
    logic             r_vld_sum;

    logic [SUM_W-1:0]  s_x    [0:ROOT_W];
    logic [REM_W-1:0]  s_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] s_root [0:ROOT_W];
    logic              s_vld  [0:ROOT_W];

    logic [SUM_W-1:0]  r_x    [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic              r_vld  [0:ROOT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sq  <= 1'b0;
            r_vld_sum <= 1'b0;
        end else begin
            r_vld_sq  <= i_vld;
            r_vld_sum <= r_vld_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_x <= SQ_W'(abs_val(i_x)) * SQ_W'(abs_val(i_x));
        r_sq_y <= SQ_W'(abs_val(i_y)) * SQ_W'(abs_val(i_y));
        r_sq_z <= SQ_W'(abs_val(i_z)) * SQ_W'(abs_val(i_z));
        r_sum  <= SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
    end

    assign s_x[0]    = r_sum;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_vld[0]  = r_vld_sum;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0] n_rem_sh;
        logic [REM_W-1:0] n_trial;
        logic             n_ge;

        always_comb begin
            n_rem_sh = {s_rem[k][REM_W-3:0], s_x[k][SUM_W-1 -: 2]};
            n_trial  = {s_root[k], 2'b01};
            n_ge     = (n_rem_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k]    <= s_x[k] << 2;
            r_rem[k]  <= n_ge ? (n_rem_sh - n_trial) : n_rem_sh;
            r_root[k] <= {s_root[k][ROOT_W-2:0], n_ge};
        end

        assign s_x[k+1]    = r_x[k];
        assign s_rem[k+1]  = r_rem[k];
        assign s_root[k+1] = r_root[k];
        assign s_vld[k+1]  = r_vld[k];
    end

    assign o_vld  = s_vld[ROOT_W];
    assign o_root = s_root[ROOT_W];

endmodule

@@ src/mmfd_merge.sv @@
module mmfd_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [mmfd_pkg::ANGLE_W-1:0] i_pitch,
    input  logic signed [mmfd_pkg::ANGLE_W-1:0] i_roll,
    input  logic [mmfd_pkg::TILT_W-1:0]        i_tilt_limit,
    input  logic                               i_accel_vld,
    input  logic                               i_rate_vld,
    input  logic [mmfd_pkg::ROOT_W-1:0]        i_accel_root,
    input  logic [mmfd_pkg::ROOT_W-1:0]        i_rate_root,
    output logic                               o_done,
    output mmfd_pkg::t_result                  o_result
);
    import mmfd_pkg::*;

    function automatic logic [ANGLE_W:0] abs_angle(input logic [ANGLE_W-1:0] v);
        logic [ANGLE_W:0] ext;
        ext = {v[ANGLE_W-1], v};
        return v[ANGLE_W-1] ? (~ext + 1'b1) : ext;
    endfunction

    function automatic logic [MAG_W-1:0] saturate(input logic [ROOT_W-1:0] root);
        return ((root >> MAG_W) != '0) ? '1 : root[MAG_W-1:0];
    endfunction

    logic [ANGLE_W:0] n_limit;
    logic             n_fall;
    logic             r_fall [0:LANE_LAT-1];
    logic             r_done;
    t_result          r_result;

    always_comb begin
        n_limit = (ANGLE_W+1)'(i_tilt_limit);
        n_fall  = (abs_angle(i_pitch) > n_limit) || (abs_angle(i_roll) > n_limit);
    end

    always_ff @(posedge i_clk) begin
        r_fall[0] <= n_fall;
        for (int j = 1; j < LANE_LAT; j++) begin
            r_fall[j] <= r_fall[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_accel_vld & i_rate_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.accel_magnitude <= saturate(i_accel_root);
        r_result.rate_magnitude  <= saturate(i_rate_root);
        r_result.fall_detected   <= r_fall[LANE_LAT-1];
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ src/motion_magnitude_fall_detect_top.sv @@
// Motion magnitude and tilt fall detector.
// Input channel: an item (three accelerometer axes, three gyroscope axes,
// pitch and roll) is taken at a rising edge where start is high and busy is
// low. Busy stays low, so a new item may be started in every cycle.
// Output channel: o_done is high for exactly one cycle with o_result valid in
// that cycle; the receiver must take it then and cannot stall the block.
// Each item gives one result: both vector magnitudes and the fall flag.
// From the accepting edge, an item passes the register for the squares, the
// register for the sum, the square-root pipeline stages (one root bit per
// pipeline stage) and the output register.
// Throughput is one item per cycle, set by the fully pipelined root stages.
// Configuration: i_cfg_we writes i_cfg_wdata into the tilt limit register.
// Reset clears all pipeline valid bits, so items in flight are dropped, and
// loads the tilt limit with 6000 (60 degrees).
module motion_magnitude_fall_detect_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mmfd_pkg::t_in_item            i_item,
    output logic                          o_done,
    output mmfd_pkg::t_result             o_result,
    input  logic                          i_cfg_we,
    input  logic [mmfd_pkg::TILT_W-1:0]   i_cfg_wdata
);
    import mmfd_pkg::*;

    logic [TILT_W-1:0] r_tilt_limit;
    logic              n_accept;
    logic              s_accel_vld;
    logic              s_rate_vld;
    logic [ROOT_W-1:0] s_accel_root;
    logic [ROOT_W-1:0] s_rate_root;

    assign busy     = 1'b0;
    assign n_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_limit <= TILT_RESET;
        end else if (i_cfg_we) begin
            r_tilt_limit <= i_cfg_wdata;
        end
    end

    mmfd_lane u_accel_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (n_accept),
        .i_x     (i_item.accel_x),
        .i_y     (i_item.accel_y),
        .i_z     (i_item.accel_z),
        .o_vld   (s_accel_vld),
        .o_root  (s_accel_root)
    );

    mmfd_lane u_rate_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (n_accept),
        .i_x     (i_item.rate_x),
        .i_y     (i_item.rate_y),
        .i_z     (i_item.rate_z),
        .o_vld   (s_rate_vld),
        .o_root  (s_rate_root)
    );

    mmfd_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pitch      (i_item.pitch_angle),
        .i_roll       (i_item.roll_angle),
        .i_tilt_limit (r_tilt_limit),
        .i_accel_vld  (s_accel_vld),
        .i_rate_vld   (s_rate_vld),
        .i_accel_root (s_accel_root),
        .i_rate_root  (s_rate_root),
        .o_done       (o_done),
        .o_result     (o_result)
    );

endmodule

@@ src/mmfd_checker.sv @@
`include "motion_magnitude_fall_detect_top_defines.svh"

module mmfd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input mmfd_pkg::t_in_item          i_item,
    input logic                        o_done,
    input mmfd_pkg::t_result           o_result
);
    import mmfd_pkg::*;

    `MMFD_NEVER(a_never_busy, busy, "busy rose although the pipeline always takes an item")

    `MMFD_ASSERT(a_item_gives_result, start && !busy |-> ##OUT_LAT o_done,
        "accepted item did not produce a result at the fixed latency")

    `MMFD_ASSERT(a_result_has_item, o_done |-> $past(start && !busy, OUT_LAT),
        "result delivered without a matching accepted item")

    `MMFD_ASSERT(a_level_no_fall,
        start && !busy && (i_item.pitch_angle == '0) && (i_item.roll_angle == '0)
            |-> ##OUT_LAT !o_result.fall_detected,
        "fall flagged for a level sample")

    `MMFD_ASSERT(a_still_zero_mag,
        start && !busy && (i_item.accel_x == '0) && (i_item.accel_y == '0)
            && (i_item.accel_z == '0) |-> ##OUT_LAT (o_result.accel_magnitude == '0),
        "nonzero accelerometer magnitude for an all-zero sample")

endmodule

bind motion_magnitude_fall_detect_top mmfd_checker u_mmfd_checker (.*);
